FILE: hdl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types, character codes and helpers of the ISO 8601 timestamp checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsv_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_T     = 8'h54;  // 'T'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_Z     = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

  // Field limits
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] MONTH_MAX  = 7'd12;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } res_t;

  typedef enum logic [5:0] {
    ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_DASH1, ST_M0, ST_M1, ST_DASH2, ST_D0, ST_D1,
    ST_SEP, ST_TH0, ST_TH1, ST_AH, ST_TM0, ST_TM1, ST_AM, ST_TS0, ST_TS1, ST_AS,
    ST_FR0, ST_FR, ST_ZEND, ST_OH0, ST_OH1, ST_AOH, ST_OMN1, ST_OM0, ST_OM1,
    ST_AOM, ST_OS0, ST_OS1, ST_AOS, ST_OFR0, ST_OFR
  } parse_state_t;

  function automatic logic [4:0] days_in_month(logic [3:0] month, logic leap);
    logic [4:0] days;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  function automatic logic is_accepting(parse_state_t st);
    logic acc;
    case (st)
      ST_SEP, ST_AH, ST_AM, ST_AS, ST_FR, ST_ZEND, ST_AOH, ST_AOM, ST_AOS,
      ST_OFR:  acc = 1'b1;
      default: acc = 1'b0;
    endcase
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tsv_char_if.sv
// ----------------------------------------------------------------------------
// tsv_char_if
// Character channel: one character per transaction, with an end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsv_char_if import tsv_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tsv_res_if.sv
// ----------------------------------------------------------------------------
// tsv_res_if
// Result channel: one verdict with year, month and day per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsv_res_if import tsv_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/iso_timestamp_validator_top.sv
// ----------------------------------------------------------------------------
// iso_timestamp_validator_top
// Streaming ISO 8601 timestamp checker returning the parsed calendar date.
// ----------------------------------------------------------------------------
// The block takes one character per transaction and one character per clock,
// back to back, as long as the result register is free or being drained in
// the same cycle. A string ends with the character flagged by last_char; the
// verdict (valid_res with year, month and day, all zero for a rejected string)
// appears in the result register on the clock after that final character and
// the parser is already clear for the next string in that same cycle. Input
// ready falls only while a finished result sits unclaimed with out ready low.
// Accepted forms: YYYY-MM-DD, then optionally 'T' or space with HH[:MM[:SS[.f]]]
// and an optional zone of Z or +/-HH[MM | :MM[:SS[.f]]]. The date must be a
// real Gregorian date with year 0001-9999; the leap-year test is taken from
// the year digits as they stream in. Once a character breaks the grammar the
// string is marked failed and the rest up to the final mark is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_timestamp_validator_top import tsv_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tsv_char_if.sink    in_if,
  tsv_res_if.source   out_if
);

  // Parser state
  parse_state_t state_r, state_nxt;
  logic         failed_r, failed_nxt;
  logic [13:0]  year_r, year_nxt;
  logic [3:0]   month_r, month_nxt;
  logic [4:0]   day_r, day_nxt;
  logic [3:0]   pfd_r, pfd_nxt;       // first digit of a two-digit field
  logic         hi_div4_r, hi_div4_nxt; // century digits divisible by 4
  logic         leap_r, leap_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  res_t out_data_r, out_data_nxt;

  logic       in_fire;
  logic       last;
  logic [7:0] c;
  logic       dig;
  logic [3:0] d;
  logic [6:0] pair_val;
  logic       is_zone;
  logic       lo_div4;
  logic       lo_zero;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign c           = in_if.data.char_code;
  assign last        = in_if.data.last_char;
  assign dig         = c inside {[CH_ZERO:CH_NINE]};
  assign d           = c[3:0];
  assign pair_val    = 7'(pfd_r * 7'd10) + {3'b000, d};
  assign is_zone     = (c == CH_Z) || (c == CH_PLUS) || (c == CH_MINUS);

  // Leap year from the digits: yy%4 == (2*y_tens + y_ones)%4
  assign lo_div4 = (2'({pfd_r[0], 1'b0} + d[1:0]) == 2'b00);
  assign lo_zero = (pfd_r == 4'd0) && (d == 4'd0);

  // --------------------------------------------------------------------------
  // Next-state logic: advance the grammar, set failed on a bad character
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    failed_nxt = failed_r;
    if (!failed_r) begin
      case (state_r)
        ST_Y0: begin
          if (dig) state_nxt = ST_Y1; else failed_nxt = 1'b1;
        end
        ST_Y1: begin
          if (dig) state_nxt = ST_Y2; else failed_nxt = 1'b1;
        end
        ST_Y2: begin
          if (dig) state_nxt = ST_Y3; else failed_nxt = 1'b1;
        end
        ST_Y3: begin
          if (dig && year_nxt != 14'd0) state_nxt = ST_DASH1; else failed_nxt = 1'b1;
        end
        ST_DASH1: begin
          if (c == CH_MINUS) state_nxt = ST_M0; else failed_nxt = 1'b1;
        end
        ST_M0: begin
          if (dig) state_nxt = ST_M1; else failed_nxt = 1'b1;
        end
        ST_M1: begin
          if (dig && pair_val != 7'd0 && pair_val <= MONTH_MAX) state_nxt = ST_DASH2;
          else failed_nxt = 1'b1;
        end
        ST_DASH2: begin
          if (c == CH_MINUS) state_nxt = ST_D0; else failed_nxt = 1'b1;
        end
        ST_D0: begin
          if (dig) state_nxt = ST_D1; else failed_nxt = 1'b1;
        end
        ST_D1: begin
          if (dig && pair_val != 7'd0 &&
              pair_val <= {2'b00, days_in_month(month_r, leap_r)}) state_nxt = ST_SEP;
          else failed_nxt = 1'b1;
        end
        ST_SEP: begin
          if (c == CH_T || c == CH_SPACE) state_nxt = ST_TH0; else failed_nxt = 1'b1;
        end
        ST_TH0: begin
          if (dig) state_nxt = ST_TH1; else failed_nxt = 1'b1;
        end
        ST_TH1: begin
          if (dig && pair_val <= HOUR_MAX) state_nxt = ST_AH; else failed_nxt = 1'b1;
        end
        ST_AH, ST_AM: begin
          if (c == CH_Z) state_nxt = ST_ZEND;
          else if (c == CH_PLUS || c == CH_MINUS) state_nxt = ST_OH0;
          else if (c == CH_COLON) state_nxt = (state_r == ST_AH) ? ST_TM0 : ST_TS0;
          else failed_nxt = 1'b1;
        end
        ST_TM0: begin
          if (dig) state_nxt = ST_TM1; else failed_nxt = 1'b1;
        end
        ST_TM1: begin
          if (dig && pair_val <= MINUTE_MAX) state_nxt = ST_AM; else failed_nxt = 1'b1;
        end
        ST_TS0: begin
          if (dig) state_nxt = ST_TS1; else failed_nxt = 1'b1;
        end
        ST_TS1: begin
          if (dig && pair_val <= MINUTE_MAX) state_nxt = ST_AS; else failed_nxt = 1'b1;
        end
        ST_AS, ST_FR: begin
          if (state_r == ST_AS && c == CH_DOT) state_nxt = ST_FR0;
          else if (state_r == ST_FR && dig) state_nxt = ST_FR;
          else if (c == CH_Z) state_nxt = ST_ZEND;
          else if (is_zone) state_nxt = ST_OH0;
          else failed_nxt = 1'b1;
        end
        ST_FR0: begin
          if (dig) state_nxt = ST_FR; else failed_nxt = 1'b1;
        end
        ST_OH0: begin
          if (dig) state_nxt = ST_OH1; else failed_nxt = 1'b1;
        end
        ST_OH1: begin
          if (dig && pair_val <= HOUR_MAX) state_nxt = ST_AOH; else failed_nxt = 1'b1;
        end
        ST_AOH: begin
          // Colon starts the long minute form; a digit 0-5 the compact one
          if (c == CH_COLON) state_nxt = ST_OM0;
          else if (dig && d <= 4'd5) state_nxt = ST_OMN1;
          else failed_nxt = 1'b1;
        end
        ST_OMN1: begin
          if (dig && pair_val <= MINUTE_MAX) state_nxt = ST_ZEND; else failed_nxt = 1'b1;
        end
        ST_OM0: begin
          if (dig) state_nxt = ST_OM1; else failed_nxt = 1'b1;
        end
        ST_OM1: begin
          if (dig && pair_val <= MINUTE_MAX) state_nxt = ST_AOM; else failed_nxt = 1'b1;
        end
        ST_AOM: begin
          if (c == CH_COLON) state_nxt = ST_OS0; else failed_nxt = 1'b1;
        end
        ST_OS0: begin
          if (dig) state_nxt = ST_OS1; else failed_nxt = 1'b1;
        end
        ST_OS1: begin
          if (dig && pair_val <= MINUTE_MAX) state_nxt = ST_AOS; else failed_nxt = 1'b1;
        end
        ST_AOS: begin
          if (c == CH_DOT) state_nxt = ST_OFR0; else failed_nxt = 1'b1;
        end
        ST_OFR0: begin
          if (dig) state_nxt = ST_OFR; else failed_nxt = 1'b1;
        end
        ST_OFR: begin
          if (!dig) failed_nxt = 1'b1;
        end
        default: begin
          // Nothing may follow a Z or a compact zone minute
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: collect date fields and digits; junk after a failure is masked
  // at the result
  // --------------------------------------------------------------------------
  always_comb begin
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    pfd_nxt     = pfd_r;
    hi_div4_nxt = hi_div4_r;
    leap_nxt    = leap_r;
    if (!failed_r) begin
      case (state_r)
        ST_Y0, ST_Y1, ST_Y2, ST_Y3: year_nxt = 14'(year_r * 14'd10) + {10'd0, d};
        default: ;
      endcase
      case (state_r)
        ST_Y0, ST_Y2, ST_M0, ST_D0, ST_TH0, ST_TM0, ST_TS0, ST_OH0, ST_AOH, ST_OM0,
        ST_OS0: pfd_nxt = d;
        ST_Y1:  hi_div4_nxt = (2'({pfd_r[0], 1'b0} + d[1:0]) == 2'b00);
        ST_Y3:  leap_nxt = lo_zero ? hi_div4_r : lo_div4;
        ST_M1:  month_nxt = pair_val[3:0];
        ST_D1:  day_nxt = pair_val[4:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result: load on the final character, drop once the sink takes it
  // --------------------------------------------------------------------------
  always_comb begin
    out_data_nxt.valid_res = !failed_nxt && is_accepting(state_nxt);
    out_data_nxt.year      = out_data_nxt.valid_res ? year_nxt  : 14'd0;
    out_data_nxt.month     = out_data_nxt.valid_res ? month_nxt : 4'd0;
    out_data_nxt.day       = out_data_nxt.valid_res ? day_nxt   : 5'd0;
    out_valid_nxt          = out_valid_r && !out_if.ready;
    if (in_fire && last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_Y0;
      failed_r    <= 1'b0;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      pfd_r       <= '0;
      hi_div4_r   <= 1'b0;
      leap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (last) begin
          // Clear the parser for the next string
          state_r   <= ST_Y0;
          failed_r  <= 1'b0;
          year_r    <= '0;
          month_r   <= '0;
          day_r     <= '0;
          pfd_r     <= '0;
          hi_div4_r <= 1'b0;
          leap_r    <= 1'b0;
        end else begin
          state_r   <= state_nxt;
          failed_r  <= failed_nxt;
          year_r    <= year_nxt;
          month_r   <= month_nxt;
          day_r     <= day_nxt;
          pfd_r     <= pfd_nxt;
          hi_div4_r <= hi_div4_nxt;
          leap_r    <= leap_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> out_valid_r)
    else $error("final character did not load a result");

  a_end_clears_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (state_r == ST_Y0 && !failed_r && year_r == 14'd0))
    else $error("parser not cleared after final character");

  a_valid_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.valid_res) |->
      (out_data_r.year != 14'd0 && out_data_r.month != 4'd0 &&
       out_data_r.month <= 4'd12 && out_data_r.day != 5'd0))
    else $error("accepted result carries an impossible date");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.valid_res) |->
      (out_data_r.year == 14'd0 && out_data_r.month == 4'd0 && out_data_r.day == 5'd0))
    else $error("rejected result carries nonzero fields");

endmodule

`default_nettype wire

FILE: dv/stamp_checker.sv
// ----------------------------------------------------------------------------
// stamp_checker
// Watches the character and result channels of the timestamp validator. It
// keeps its own parser to predict each string's verdict and date, and
// compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module stamp_checker import tsv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tsv_char_if  chars,
  tsv_res_if   verdicts,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  parse_state_t pst;
  logic [13:0]  yr;
  logic [3:0]   mo;
  logic [4:0]   dy;
  logic [3:0]   tens;
  logic         dead;

  res_t verdict_q[$];
  res_t got;
  res_t want;
  logic ok;
  int   mismatch_cnt = 0;
  int   open_cnt = 0;

  assign errors  = mismatch_cnt;
  assign pending = open_cnt;

  function automatic logic is_num(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic clear_parse();
    pst  = ST_Y0;
    yr   = '0;
    mo   = '0;
    dy   = '0;
    tens = '0;
    dead = 1'b0;
  endtask

  // First digit of a two-digit field: hold it as the tens digit
  task automatic lead_digit(input logic [7:0] c, input parse_state_t nxt);
    if (!is_num(c)) begin
      dead = 1'b1;
    end else begin
      tens = c[3:0];
      pst  = nxt;
    end
  endtask

  task automatic tail_digit(input logic [7:0] c, input int ceil_v, input parse_state_t nxt);
    if (!is_num(c) || (int'(tens) * 10 + int'(c[3:0]) > ceil_v)) begin
      dead = 1'b1;
    end else begin
      pst = nxt;
    end
  endtask

  task automatic zone_open(input logic [7:0] c, output logic hit);
    hit = 1'b1;
    if (c == CH_Z) begin
      pst = ST_ZEND;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      pst = ST_OH0;
    end else begin
      hit = 1'b0;
    end
  endtask

  // Advance the predicted parser by one character
  task automatic parse_char(input logic [7:0] c);
    int   v;
    int   lim;
    logic hit;
    v = int'(tens) * 10 + int'(c[3:0]);
    case (pst)
      ST_Y0, ST_Y1, ST_Y2, ST_Y3: begin
        if (!is_num(c)) begin
          dead = 1'b1;
        end else begin
          yr = yr * 14'd10 + {10'd0, c[3:0]};
          if (pst == ST_Y3 && yr == 14'd0) dead = 1'b1;
          else pst = parse_state_t'(pst + 6'd1);
        end
      end
      ST_DASH1: begin
        if (c == CH_MINUS) pst = ST_M0;
        else dead = 1'b1;
      end
      ST_M0: lead_digit(c, ST_M1);
      ST_M1: begin
        if (!is_num(c) || v < 1 || v > 12) begin
          dead = 1'b1;
        end else begin
          mo  = v[3:0];
          pst = ST_DASH2;
        end
      end
      ST_DASH2: begin
        if (c == CH_MINUS) pst = ST_D0;
        else dead = 1'b1;
      end
      ST_D0: lead_digit(c, ST_D1);
      ST_D1: begin
        case (int'(mo))
          1, 3, 5, 7, 8, 10, 12: lim = 31;
          4, 6, 9, 11:           lim = 30;
          2: lim = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 29 : 28;
          default:               lim = 0;
        endcase
        if (!is_num(c) || v < 1 || v > lim) begin
          dead = 1'b1;
        end else begin
          dy  = v[4:0];
          pst = ST_SEP;
        end
      end
      ST_SEP: begin
        if (c == CH_T || c == CH_SPACE) pst = ST_TH0;
        else dead = 1'b1;
      end
      ST_TH0: lead_digit(c, ST_TH1);
      ST_TH1: tail_digit(c, 23, ST_AH);
      ST_AH, ST_AM: begin
        zone_open(c, hit);
        if (!hit) begin
          if (c == CH_COLON) pst = (pst == ST_AH) ? ST_TM0 : ST_TS0;
          else dead = 1'b1;
        end
      end
      ST_TM0: lead_digit(c, ST_TM1);
      ST_TM1: tail_digit(c, 59, ST_AM);
      ST_TS0: lead_digit(c, ST_TS1);
      ST_TS1: tail_digit(c, 59, ST_AS);
      ST_AS: begin
        if (c == CH_DOT) begin
          pst = ST_FR0;
        end else begin
          zone_open(c, hit);
          if (!hit) dead = 1'b1;
        end
      end
      ST_FR0: begin
        if (is_num(c)) pst = ST_FR;
        else dead = 1'b1;
      end
      ST_FR: begin
        if (!is_num(c)) begin
          zone_open(c, hit);
          if (!hit) dead = 1'b1;
        end
      end
      ST_OH0: lead_digit(c, ST_OH1);
      ST_OH1: tail_digit(c, 23, ST_AOH);
      ST_AOH: begin
        if (c == CH_COLON) begin
          pst = ST_OM0;
        end else begin
          lead_digit(c, ST_OMN1);
          if (!dead && tens > 4'd5) dead = 1'b1;
        end
      end
      ST_OMN1: tail_digit(c, 59, ST_ZEND);
      ST_OM0:  lead_digit(c, ST_OM1);
      ST_OM1:  tail_digit(c, 59, ST_AOM);
      ST_AOM: begin
        if (c == CH_COLON) pst = ST_OS0;
        else dead = 1'b1;
      end
      ST_OS0: lead_digit(c, ST_OS1);
      ST_OS1: tail_digit(c, 59, ST_AOS);
      ST_AOS: begin
        if (c == CH_DOT) pst = ST_OFR0;
        else dead = 1'b1;
      end
      ST_OFR0: begin
        if (is_num(c)) pst = ST_OFR;
        else dead = 1'b1;
      end
      ST_OFR: begin
        if (!is_num(c)) dead = 1'b1;
      end
      default: dead = 1'b1;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      verdict_q.delete();
    end else begin
      if (chars.valid && chars.ready) begin
        if (!dead) parse_char(chars.data.char_code);
        if (chars.data.last_char) begin
          case (pst)
            ST_SEP, ST_AH, ST_AM, ST_AS, ST_FR, ST_ZEND, ST_AOH, ST_AOM, ST_AOS,
            ST_OFR:  ok = !dead;
            default: ok = 1'b0;
          endcase
          want.valid_res = ok;
          want.year      = ok ? yr : '0;
          want.month     = ok ? mo : '0;
          want.day       = ok ? dy : '0;
          verdict_q.push_back(want);
          clear_parse();
        end
      end
      if (verdicts.valid && verdicts.ready) begin
        got = verdicts.data;
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("chk: unexpected result valid=%0d y=%0d m=%0d d=%0d",
                     got.valid_res, got.year, got.month, got.day);
        end else begin
          want = verdict_q.pop_front();
          if (got.valid_res !== want.valid_res || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("chk: mismatch exp valid=%0d y=%0d m=%0d d=%0d, got valid=%0d y=%0d m=%0d d=%0d",
                       want.valid_res, want.year, want.month, want.day,
                       got.valid_res, got.year, got.month, got.day);
          end
        end
      end
    end
    open_cnt = verdict_q.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ISO 8601 timestamp validator. Feeds directed
// timestamps, then random well-formed strings with random content, broken
// strings and raw noise, with random idling on both channels. The checker
// beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb import tsv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1150;    // characters to offer in total
  localparam int PARK_CYCLES = 300;     // long receiver hold-off
  localparam int TAIL_CYCLES = 20;      // settle time after the last result
  localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest legal run

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tsv_char_if in_if ();
  tsv_res_if  out_if ();

  int fail_cnt;
  int open_cnt;
  int cycle_cnt = 0;
  int sent = 0;

  // Idling control: calm modes give stretches with no gaps at all
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  // The sender requests one long hold-off; the receiver acknowledges it
  bit rx_park_req = 1'b0;
  bit rx_park_done = 1'b0;

  // String under construction, one byte per character
  logic [7:0] txt[$];

  iso_timestamp_validator_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  stamp_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .chars    (in_if),
    .verdicts (out_if),
    .errors   (fail_cnt),
    .pending  (open_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one character; return once the transaction has been accepted.
  // Valid stays high across back-to-back transactions, so within this task it
  // is lowered only when a gap is drawn.
  task automatic put_char(input logic [7:0] c, input logic fin);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = {c, fin};
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // Send the built string, marking its final character
  task automatic send_txt();
    for (int i = 0; i < txt.size(); i++)
      put_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_str(input string s);
    txt.delete();
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_txt();
  endtask

  // Append v as exactly n decimal digits
  task automatic add_num(input int v, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      txt.push_back(8'(CH_ZERO + ((v / div) % 10)));
      div /= 10;
    end
  endtask

  // Mostly a legal value 0..hi, now and then a value from hi+1 to 99
  function automatic int pick_val(input int hi);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(hi + 1, 99) : $urandom_range(0, hi);
  endfunction

  task automatic add_noise(input int max_len);
    repeat ($urandom_range(1, max_len)) txt.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build a random timestamp: mostly well formed, sometimes with an illegal
  // field, sometimes damaged afterward by a replaced, cut or extra character.
  task automatic make_stamp();
    int y;
    int m;
    int d;
    int keep;
    txt.delete();
    case ($urandom_range(0, 19))
      0:       y = 0;
      1:       y = 1;
      2:       y = 9999;
      3:       y = 1900;
      4:       y = 2000;
      5:       y = 2100;
      6:       y = 4 * $urandom_range(1, 2499);
      default: y = $urandom_range(1, 9999);
    endcase
    case ($urandom_range(0, 19))
      0:          m = 0;
      1:          m = $urandom_range(13, 99);
      2, 3, 4, 5: m = 2;
      default:    m = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 19))
      0:          d = 0;
      1:          d = $urandom_range(32, 99);
      2, 3, 4, 5: d = $urandom_range(29, 31);
      default:    d = $urandom_range(1, 28);
    endcase
    add_num(y, 4);
    txt.push_back(CH_MINUS);
    add_num(m, 2);
    txt.push_back(CH_MINUS);
    add_num(d, 2);

    if ($urandom_range(0, 4) != 0) begin
      txt.push_back($urandom_range(0, 1) ? CH_T : CH_SPACE);
      add_num(pick_val(23), 2);
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          txt.push_back(CH_COLON);
          add_num(pick_val(59), 2);
        end
        default: begin
          txt.push_back(CH_COLON);
          add_num(pick_val(59), 2);
          txt.push_back(CH_COLON);
          add_num(pick_val(59), 2);
          if ($urandom_range(0, 1)) begin
            txt.push_back(CH_DOT);
            repeat ($urandom_range(0, 4))
              txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          end
        end
      endcase
      // Zone: none, Z, or a signed offset in one of its spellings
      case ($urandom_range(0, 3))
        0: ;
        1: txt.push_back(CH_Z);
        default: begin
          txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          add_num(pick_val(23), 2);
          case ($urandom_range(0, 3))
            0: ;
            1: add_num(pick_val(59), 2);
            2: begin
              txt.push_back(CH_COLON);
              add_num(pick_val(59), 2);
            end
            default: begin
              txt.push_back(CH_COLON);
              add_num(pick_val(59), 2);
              txt.push_back(CH_COLON);
              add_num(pick_val(59), 2);
              if ($urandom_range(0, 1)) begin
                txt.push_back(CH_DOT);
                repeat ($urandom_range(0, 3))
                  txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
              end
            end
          endcase
        end
      endcase
    end

    case ($urandom_range(0, 9))
      0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        keep = $urandom_range(1, txt.size() - 1);
        while (txt.size() > keep) void'(txt.pop_back());
      end
      2: txt.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // Pause the sender until every predicted result has been claimed
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (open_cnt != 0) @(negedge clk);
  endtask

  // Receiver: draw a stall per result, with calm stretches, and take the one
  // long hold-off when the sender asks for it.
  initial begin : rx_side
    int stall;
    out_if.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_park_req && !rx_park_done) begin
        out_if.ready = 1'b0;
        repeat (PARK_CYCLES) @(negedge clk);
        rx_park_done = 1'b1;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        stall = rx_calm ? 0 : $urandom_range(0, 12);
        if (stall != 0) begin
          out_if.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  initial begin : tx_side
    bit paused;
    paused = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, leap rules, bad dates, short strings,
    // every zone spelling and characters after the end of a string
    send_str("0001-01-01");
    send_str("9999-12-31T23:59:59.999999+23:59:59.99");
    send_str("0000-06-15");
    send_str("2000-02-29");
    send_str("1900-02-29");
    send_str("2023-02-29");
    send_str("2024-02-29T00Z");
    send_str("2021-04-31");
    send_str("2021-13-01");
    send_str("2021-00-10");
    send_str("2021-06-00");
    send_str("2021-06-15T");
    send_str("2021-06-15 24");
    send_str("2021-06-15T12:60");
    send_str("2021-06-15T12:30-0530");
    send_str("2021-06-15T12+0630");
    send_str("2021-06-15T12:30:45Z1");
    send_str("2021-06-15T12:30+05");
    send_str("2021-06-15T12:30:45.5-05:30");
    send_str("2021-06-15T12:30:45-05:30:15.");
    send_str("2021-06-15T1-:00");
    send_str("2021-06-15T07:08:09.");
    send_str("7");
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b1);

    // Back-pressure: park the receiver and keep offering short strings so
    // the result register fills and the input stalls
    rx_park_req = 1'b1;
    repeat (40) begin
      txt.delete();
      add_noise(2);
      send_txt();
    end

    // Random: mostly timestamps, some raw noise; one full drain halfway
    while (sent < ITEMS) begin
      if (!paused && sent > ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        txt.delete();
        add_noise(6);
      end else begin
        make_stamp();
      end
      send_txt();
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (open_cnt != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tsv_pkg.sv
hdl/tsv_char_if.sv
hdl/tsv_res_if.sv
hdl/iso_timestamp_validator_top.sv
dv/stamp_checker.sv
dv/tb.sv
